### hdl/pai_pkg.sv
// Shared types and constants for the Pareto archive insert unit.
// No dependencies; imported by the top, pai_cmp, pai_checker and the bench.
package pai_pkg;

	// Default configuration
	localparam int DEPTH_DEF     = 64;
	localparam int COST_BITS_DEF = 32;

	// Fixed field widths on the stream ports
	localparam int IN_COST_W = 32;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 7;
	localparam int TAG_W     = 16;
	localparam int MODE_W    = 2;

	// Stream payload widths (padded to whole bytes)
	localparam int IN_PAY_W   = 2 * IN_COST_W + SLOT_W;
	localparam int IN_TDATA_W = ((IN_PAY_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 2 + 2 * CNT_W + 2 * TAG_W + 2 * IN_COST_W;

	// Request kinds carried on s_axis_tuser
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// Result of the shared compare unit
	typedef struct packed {
		logic covers;     // stored pair no worse than candidate in both costs
		logic dominates;  // candidate strictly dominates stored pair
	} cmp_res_t;

endpackage

### hdl/pareto_archive_insert_unit.sv
// Pareto archive insert unit: top level, sequencer and result register.
// Depends on pai_pkg, pai_mem and pai_cmp.
//
// Usage
//   Input beats arrive on s_axis_*; tuser carries the request kind (insert,
//   read, clear), tdata the candidate costs and the read slot. Each beat
//   yields exactly one result beat on m_axis_*.
//   Insert: the stored pairs are streamed out of the archive RAM one per
//   cycle through a single compare unit. A covering entry aborts the scan
//   (nothing has moved yet, the archive stays non-dominated). Otherwise
//   dominated entries are dropped and survivors written back compacted in
//   the same pass, then the candidate is appended.
//   Steps: insert goes through SCAN, one read per stored entry, then APPEND
//   and DONE; a covering entry jumps straight to DONE, an empty archive
//   skips SCAN. Read passes READ and DONE, clear and unused kinds go to DONE.
//   The next beat is taken in the cycle after the result is loaded.
//   One item is in flight at a time: s_axis_tready is high only while the
//   sequencer is idle. The result sits in an output register, so a new
//   item is taken while a finished result waits; if the receiver is still
//   stalled when the next result is ready, the sequencer holds it.
//   Reset clears the entry count and the control state; archive RAM
//   contents are left alone and never read past the count.
module pareto_archive_insert_unit #(
	parameter int ARCHIVE_DEPTH = pai_pkg::DEPTH_DEF,
	parameter int COST_BITS     = pai_pkg::COST_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: cost_first[31:0], cost_second[63:32], read_slot[69:64], zero pad
	input  logic [pai_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [pai_pkg::MODE_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: accepted[0], full_drop[1], removed_count[8:2], entry_count[15:9],
	//        assigned_tag[31:16], read_first[63:32], read_second[95:64],
	//        read_tag[111:96]
	output logic [pai_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import pai_pkg::*;

	localparam int AW = $clog2(ARCHIVE_DEPTH);
	localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
	localparam int EW = 2 * COST_BITS + TAG_W;
	localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_APPEND = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]           state_q;
	logic [MODE_W-1:0]    mode_q;
	logic [COST_BITS-1:0] cand1_q, cand2_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CW-1:0]        occ_q;      // entries in the archive
	logic [CW-1:0]        issue_q;    // next entry to read
	logic [CW-1:0]        kept_q;     // survivors written back so far
	logic [CW-1:0]        removed_q;
	logic                 pend_s1;    // read data for a scan entry is valid
	logic [TAG_W-1:0]     last_tag_q; // tag of the last survivor
	logic [TAG_W-1:0]     tag_q;
	logic                 acc_q, full_q, rd_hit_q;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                 s_beat, out_free;
	logic                 scan_issue, keep_ent, do_append, rd_hit;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [EW-1:0]        mem_wdata, mem_rdata;
	logic [COST_BITS-1:0] ent_first, ent_second;
	logic [TAG_W-1:0]     ent_tag, new_tag;
	cmp_res_t             cmp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_beat        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign ent_first  = mem_rdata[COST_BITS-1:0];
	assign ent_second = mem_rdata[2*COST_BITS-1:COST_BITS];
	assign ent_tag    = mem_rdata[EW-1:2*COST_BITS];

	pai_cmp #(
		.COST_BITS (COST_BITS)
	) u_cmp (
		.ent_first   (ent_first),
		.ent_second  (ent_second),
		.cand_first  (cand1_q),
		.cand_second (cand2_q),
		.res         (cmp)
	);

	always_comb begin
		scan_issue = (state_q == ST_SCAN) && (issue_q < occ_q);
		rd_hit     = SW'(slot_q) < SW'(occ_q);
		keep_ent   = (state_q == ST_SCAN) && pend_s1 && !cmp.covers && !cmp.dominates;
		do_append  = (state_q == ST_APPEND) && (kept_q < CW'(ARCHIVE_DEPTH));
		new_tag    = (kept_q == '0) ? '0 : last_tag_q + TAG_W'(1);

		mem_re    = scan_issue || ((state_q == ST_READ) && rd_hit);
		mem_raddr = (state_q == ST_SCAN) ? issue_q[AW-1:0] : AW'(slot_q);
		// survivors and the appended pair both land at the compaction point
		mem_we    = keep_ent || do_append;
		mem_waddr = kept_q[AW-1:0];
		mem_wdata = do_append ? {new_tag, cand2_q, cand1_q} : mem_rdata;
	end

	pai_mem #(
		.DEPTH (ARCHIVE_DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load wins over drain: a taken beat is replaced in the same cycle
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (s_beat) begin
						case (s_axis_tuser)
							MODE_INSERT: state_q <= (occ_q == '0) ? ST_APPEND : ST_SCAN;
							MODE_READ:   state_q <= ST_READ;
							MODE_CLEAR: begin
								occ_q   <= '0;
								state_q <= ST_DONE;
							end
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					pend_s1 <= scan_issue;
					if (pend_s1 && cmp.covers) begin
						state_q <= ST_DONE;
					end else if (!pend_s1 && !scan_issue) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					occ_q   <= do_append ? kept_q + CW'(1) : kept_q;
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (s_beat) begin
			mode_q    <= s_axis_tuser;
			cand1_q   <= COST_BITS'(s_axis_tdata[IN_COST_W-1:0]);
			cand2_q   <= COST_BITS'(s_axis_tdata[2*IN_COST_W-1:IN_COST_W]);
			slot_q    <= s_axis_tdata[IN_PAY_W-1:2*IN_COST_W];
			issue_q   <= '0;
			kept_q    <= '0;
			removed_q <= '0;
			tag_q     <= '0;
			acc_q     <= 1'b0;
			full_q    <= 1'b0;
			rd_hit_q  <= 1'b0;
		end
		if (scan_issue) begin
			issue_q <= issue_q + CW'(1);
		end
		if (state_q == ST_SCAN && pend_s1 && !cmp.covers) begin
			if (cmp.dominates) begin
				removed_q <= removed_q + CW'(1);
			end else begin
				kept_q     <= kept_q + CW'(1);
				last_tag_q <= ent_tag;
			end
		end
		if (state_q == ST_APPEND) begin
			acc_q  <= do_append;
			full_q <= !do_append;
			if (do_append) begin
				tag_q <= new_tag;
			end
		end
		if (state_q == ST_READ) begin
			rd_hit_q <= rd_hit && (mode_q == MODE_READ);
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {
				rd_hit_q ? ent_tag : TAG_W'(0),
				rd_hit_q ? IN_COST_W'(ent_second) : IN_COST_W'(0),
				rd_hit_q ? IN_COST_W'(ent_first) : IN_COST_W'(0),
				tag_q,
				CNT_W'(occ_q),
				CNT_W'(removed_q),
				full_q,
				acc_q
			};
		end
	end

endmodule

### hdl/pai_mem.sv
// Archive storage: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module pai_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/pai_cmp.sv
// Shared dominance compare unit: one magnitude compare per objective.
// Depends on pai_pkg for the result struct.
module pai_cmp #(
	parameter int COST_BITS = 32
) (
	input  logic [COST_BITS-1:0] ent_first,
	input  logic [COST_BITS-1:0] ent_second,
	input  logic [COST_BITS-1:0] cand_first,
	input  logic [COST_BITS-1:0] cand_second,
	output pai_pkg::cmp_res_t    res
);
	import pai_pkg::*;

	logic lt1, lt2, eq1, eq2;

	always_comb begin
		lt1 = ent_first < cand_first;
		lt2 = ent_second < cand_second;
		eq1 = ent_first == cand_first;
		eq2 = ent_second == cand_second;
		res.covers    = (lt1 || eq1) && (lt2 || eq2);
		// candidate <= entry in both, and not equal in both
		res.dominates = !lt1 && !lt2 && !(eq1 && eq2);
	end

endmodule

### hdl/pai_checker.sv
// Port-level checks for the Pareto archive insert unit, bound to the top.
// Depends on pai_pkg and pareto_archive_insert_unit.
module pai_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pai_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import pai_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// one item in flight: busy right after taking a beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// an accepted pair leaves at least one entry
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[15:9] != 7'd0)
		else $error("accepted with empty archive");

	// a full drop removed nothing and stored nothing
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0] && m_axis_tdata[8:2] == 7'd0)
		else $error("full drop with removal or accept");

endmodule

bind pareto_archive_insert_unit pai_checker u_pai_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### bench/tb_pareto_archive_insert_unit.sv
// Self-checking bench for pareto_archive_insert_unit: directed table, then random traffic.
// Expects results from its own archive copy or a typed row; compares field by field.
// Depends on pai_pkg and the unit's RTL only.
module tb_pareto_archive_insert_unit;
	import pai_pkg::*;

	localparam int                DEPTH       = DEPTH_DEF;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int                ITEM_TOTAL  = 1450;
	localparam int                STALL_LIMIT = 5000;  // cycles with no beat on either side

	// result beat, accepted in bit 0
	typedef struct packed {
		logic [TAG_W-1:0]     read_tag;
		logic [IN_COST_W-1:0] read_second;
		logic [IN_COST_W-1:0] read_first;
		logic [TAG_W-1:0]     assigned_tag;
		logic [CNT_W-1:0]     entry_count;
		logic [CNT_W-1:0]     removed_count;
		logic                 full_drop;
		logic                 accepted;
	} result_t;

	typedef struct {
		logic [MODE_W-1:0]    mode;
		logic [IN_COST_W-1:0] c1;
		logic [IN_COST_W-1:0] c2;
		logic [SLOT_W-1:0]    slot;
		bit                   typed;  // res holds a hand-written expectation
		result_t              res;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]      s_tuser = '0;
	logic                   m_tready = 1'b0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor's archive copy
	logic [IN_COST_W-1:0] arc_first [DEPTH];
	logic [IN_COST_W-1:0] arc_second[DEPTH];
	logic [TAG_W-1:0]     arc_tag   [DEPTH];
	int                   arc_count = 0;

	result_t   pending_results[$];
	stim_row_t directed_rows[$];
	int        fail_count = 0;
	int        sent = 0;
	int        quiet_cycles = 0;
	bit        calm = 1'b0;  // no idling on either side while set

	pareto_archive_insert_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Applies one request to the archive copy and returns the result beat it should give.
	function automatic result_t archive_apply(logic [MODE_W-1:0] mode,
		logic [IN_COST_W-1:0] c1, logic [IN_COST_W-1:0] c2, logic [SLOT_W-1:0] slot);
		result_t r;
		bit      blocked;
		int      kept;
		r = '0;
		blocked = 1'b0;
		kept = 0;
		case (mode)
			MODE_INSERT: begin
				// any stored pair equal to or better than the candidate blocks it
				for (int i = 0; i < arc_count; i++)
					if (arc_first[i] <= c1 && arc_second[i] <= c2)
						blocked = 1'b1;
				if (!blocked) begin
					// drop dominated entries, compact survivors in order
					for (int i = 0; i < arc_count; i++) begin
						if (c1 <= arc_first[i] && c2 <= arc_second[i]) begin
							r.removed_count++;
						end else begin
							arc_first[kept]  = arc_first[i];
							arc_second[kept] = arc_second[i];
							arc_tag[kept]    = arc_tag[i];
							kept++;
						end
					end
					arc_count = kept;
					if (arc_count >= DEPTH) begin
						r.full_drop = 1'b1;  // nothing removed and no free slot
					end else begin
						r.assigned_tag = (arc_count > 0) ? arc_tag[arc_count-1] + 1'b1 : '0;
						arc_first[arc_count]  = c1;
						arc_second[arc_count] = c2;
						arc_tag[arc_count]    = r.assigned_tag;
						arc_count++;
						r.accepted = 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (slot < arc_count) begin
					r.read_first  = arc_first[slot];
					r.read_second = arc_second[slot];
					r.read_tag    = arc_tag[slot];
				end
			end
			MODE_CLEAR: arc_count = 0;
			default: ;
		endcase
		r.entry_count = arc_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic result_t mk_res(logic acc, logic full, int rem, int cnt, int tag,
		logic [IN_COST_W-1:0] rf, logic [IN_COST_W-1:0] rs, int rt);
		result_t r;
		r.accepted      = acc;
		r.full_drop     = full;
		r.removed_count = rem[CNT_W-1:0];
		r.entry_count   = cnt[CNT_W-1:0];
		r.assigned_tag  = tag[TAG_W-1:0];
		r.read_first    = rf;
		r.read_second   = rs;
		r.read_tag      = rt[TAG_W-1:0];
		return r;
	endfunction

	task automatic add_row(logic [MODE_W-1:0] mode, logic [IN_COST_W-1:0] c1,
		logic [IN_COST_W-1:0] c2, logic [SLOT_W-1:0] slot, bit typed, result_t res);
		stim_row_t row;
		row.mode  = mode;
		row.c1    = c1;
		row.c2    = c2;
		row.slot  = slot;
		row.typed = typed;
		row.res   = res;
		directed_rows = {directed_rows, row};
	endtask

	// Drives one input beat, waits for its handshake, then books the expected result.
	task automatic send_request(logic [MODE_W-1:0] mode, logic [IN_COST_W-1:0] c1,
		logic [IN_COST_W-1:0] c2, logic [SLOT_W-1:0] slot, bit typed, result_t typed_res);
		result_t predicted;
		while (!calm && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_PAY_W){1'b0}}, slot, c2, c1};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		predicted = archive_apply(mode, c1, c2, slot);
		if (typed)
			predicted = typed_res;
		pending_results = {pending_results, predicted};
		sent++;
		calm = (sent >= 600 && sent < 850);
	endtask

	// Sender holds off until every booked result has come back.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, e, a);
			fail_count++;
		end
	endtask

	// Receiver: stalls about a quarter of the cycles outside the calm stretch.
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 25);

	// Result monitor: one result beat per handshake, compared against the oldest booking.
	always @(posedge clk) begin
		result_t act, exp_res;
		if (arst_n && m_axis_tvalid && m_tready) begin
			act = result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, got 0x%h", $time, m_axis_tdata);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				check_field("accepted", exp_res.accepted, act.accepted);
				check_field("full_drop", exp_res.full_drop, act.full_drop);
				check_field("removed_count", exp_res.removed_count, act.removed_count);
				check_field("entry_count", exp_res.entry_count, act.entry_count);
				check_field("assigned_tag", exp_res.assigned_tag, act.assigned_tag);
				check_field("read_first", exp_res.read_first, act.read_first);
				check_field("read_second", exp_res.read_second, act.read_second);
				check_field("read_tag", exp_res.read_tag, act.read_tag);
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [IN_COST_W-1:0] x, y;
		int                   n, j, k, pick;
		bit                   first_pass;
		result_t              none;
		none = '0;
		first_pass = 1'b1;

		// Directed rows. Empty archive first: reads, unused kind, clear.
		add_row(MODE_READ,   0, 0, 0,  1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_READ,   0, 0, 63, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_UNUSED, '1, '1, 63, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_CLEAR,  0, 0, 0,  1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		// first insert into empty archive gets tag 0; an equal pair is rejected
		add_row(MODE_INSERT, '1, '1, 0, 1, mk_res(1, 0, 0, 1, 0, 0, 0, 0));
		add_row(MODE_INSERT, '1, '1, 0, 1, mk_res(0, 0, 0, 1, 0, 0, 0, 0));
		// dominates the only entry: removed, nothing survives, tag restarts at 0
		add_row(MODE_INSERT, '1, 32'hFFFF_FFFE, 0, 1, mk_res(1, 0, 1, 1, 0, 0, 0, 0));
		add_row(MODE_READ,   0, 0, 0, 1, mk_res(0, 0, 0, 1, 0, '1, 32'hFFFF_FFFE, 0));
		add_row(MODE_INSERT, 0, '1, 0, 1, mk_res(1, 0, 0, 2, 1, 0, 0, 0));
		add_row(MODE_READ,   0, 0, 1, 1, mk_res(0, 0, 0, 2, 0, 0, '1, 1));
		add_row(MODE_READ,   0, 0, 2, 1, mk_res(0, 0, 0, 2, 0, 0, 0, 0));
		add_row(MODE_INSERT, 1, 1, 0, 0, none);
		add_row(MODE_INSERT, 2, 2, 0, 0, none);
		// origin dominates everything stored
		add_row(MODE_INSERT, 0, 0, 0, 1, mk_res(1, 0, 2, 1, 0, 0, 0, 0));
		add_row(MODE_INSERT, 0, 1, 0, 1, mk_res(0, 0, 0, 1, 0, 0, 0, 0));
		add_row(MODE_UNUSED, 0, 0, 0, 1, mk_res(0, 0, 0, 1, 0, 0, 0, 0));
		add_row(MODE_CLEAR,  '1, '1, 63, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_READ,   0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1, mk_res(1, 0, 0, 1, 0, 0, 0, 0));
		add_row(MODE_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1, mk_res(1, 0, 0, 2, 1, 0, 0, 0));
		add_row(MODE_READ,   0, 0, 63, 1, mk_res(0, 0, 0, 2, 0, 0, 0, 0));
		add_row(MODE_INSERT, 0, '1, 42, 0, none);
		add_row(MODE_READ,   0, 0, 2, 0, none);
		add_row(MODE_CLEAR,  0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_request(directed_rows[r].mode, directed_rows[r].c1, directed_rows[r].c2,
				directed_rows[r].slot, directed_rows[r].typed, directed_rows[r].res);

		// Random part, mostly well-formed archive traffic.
		while (sent < ITEM_TOTAL) begin
			pick = first_pass ? 0 : $urandom_range(0, 9);
			if (first_pass || $urandom_range(0, 7) == 0)
				hold_until_drained();
			case (pick)
				0, 1, 2, 3: begin
					// staircase of mutually non-dominated pairs; long runs overfill
					if (first_pass || $urandom_range(0, 1) == 0)
						send_request(MODE_CLEAR, $urandom, $urandom,
							SLOT_W'($urandom_range(0, 63)), 0, none);
					n = first_pass ? 72 : $urandom_range(10, 72);
					x = $urandom_range(0, 32'h000F_FFFF);
					y = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
					for (int s = 0; s < n; s++) begin
						x += $urandom_range(1, 5000);
						y -= $urandom_range(1, 5000);
						send_request(MODE_INSERT, x, y, SLOT_W'($urandom_range(0, 63)), 0, none);
						if ($urandom_range(0, 4) == 0)
							send_request(MODE_READ, 0, 0,
								SLOT_W'($urandom_range(0, (arc_count > 63) ? 63 : arc_count)),
								0, none);
					end
					// a pair built from two entries knocks out the band between them
					for (int s = $urandom_range(0, 3); s > 0; s--) begin
						if (arc_count >= 2) begin
							j = $urandom_range(0, arc_count - 2);
							k = $urandom_range(j + 1, arc_count - 1);
							send_request(MODE_INSERT, arc_first[j], arc_second[k], 0, 0, none);
						end
					end
				end
				4, 5: begin
					// tiny cost range: many ties, rejections and removals
					n = $urandom_range(5, 40);
					for (int s = 0; s < n; s++) begin
						if ($urandom_range(0, 5) == 0)
							send_request(MODE_READ, 0, 0, SLOT_W'($urandom_range(0, 63)), 0, none);
						else
							send_request(MODE_INSERT, $urandom_range(0, 15), $urandom_range(0, 15),
								SLOT_W'($urandom_range(0, 63)), 0, none);
					end
				end
				6, 7: begin
					// sweep every live slot, plus the first one past the end when the archive is not full
					n = (arc_count > 63) ? 63 : arc_count;
					for (int s = 0; s <= n; s++)
						send_request(MODE_READ, $urandom, $urandom, SLOT_W'(s), 0, none);
				end
				8: begin
					// noise: any kind, full-range fields
					n = $urandom_range(5, 30);
					for (int s = 0; s < n; s++)
						send_request(MODE_W'($urandom_range(0, 3)), $urandom, $urandom,
							SLOT_W'($urandom_range(0, 63)), 0, none);
				end
				default: begin
					send_request(MODE_UNUSED, $urandom, $urandom,
						SLOT_W'($urandom_range(0, 63)), 0, none);
					send_request(MODE_CLEAR, $urandom, $urandom,
						SLOT_W'($urandom_range(0, 63)), 0, none);
				end
			endcase
			first_pass = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// any stray beat would show up here
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
